// File: rtl/core/rgbc_color_temperature_processor_macros.svh
// Assertion macros shared by the color temperature processor RTL
`ifndef RGBC_COLOR_TEMPERATURE_PROCESSOR_MACROS_SVH
`define RGBC_COLOR_TEMPERATURE_PROCESSOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RGBC_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RGBC_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

// File: rtl/core/rgbc_pkg.sv
// Shared types, constants and coefficient tables of the color temperature processor
package rgbc_pkg;

	localparam int AVG_WEIGHT_LOG2_DEF = 2;
	localparam int CHANNEL_WIDTH_DEF   = 16;

	localparam int IN_W    = 16;   // raw sample and channel output width
	localparam int VW      = 17;   // channel value after compensation
	localparam int XW      = 40;   // XYZ and their sum, Q.16
	localparam int ND_W    = 44;   // n numerator / denominator
	localparam int N_W     = 24;   // n, Q.16 signed
	localparam int N2_W    = 30;
	localparam int N3_W    = 36;
	localparam int ACC_W   = 56;   // cubic accumulator
	localparam int ILL_W   = 19;
	localparam int QDEPTH  = 2;

	localparam int DIV_QB  = 24;   // quotient bits
	localparam int DIV_DW  = ND_W + 16;
	localparam int DIV_VW  = ND_W;
	localparam int DIV_STEPS = DIV_QB / 2;

	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COMPENSATE = 2'd0,
		CFG_PERCENTAGE = 2'd1
	} cfg_idx_t;

	localparam logic [4:0]  COMP_G_MUL = 5'd21;       // 1.3125 as 21/16
	localparam logic [16:0] COMP_B_MUL = 17'd104681;  // 1.5973 in Q.16

	// RGB to XYZ, Q2.16
	localparam logic signed [VW:0] MAT [3][3] = '{
		'{-18'sd9360,  18'sd101531, -18'sd62679},
		'{-18'sd21277, 18'sd103440, -18'sd47966},
		'{-18'sd44697, 18'sd50511,   18'sd36918}
	};

	localparam logic signed [15:0] X_COEF = 16'sd21758;  // 0.3320
	localparam logic signed [15:0] Y_COEF = 16'sd12177;  // 0.1858

	localparam logic [N_W-1:0] N_LIMIT = 24'd4194304;    // 64.0 in Q.16

	localparam logic signed [17:0] CCT_C3 = 18'sd44900;
	localparam logic signed [20:0] CCT_C2 = 21'sd352500;
	localparam logic signed [21:0] CCT_C1 = 22'sd682330;
	localparam logic signed [ACC_W-1:0] CCT_C0 = 56'sd36178034688;  // 552033 << 16

	localparam logic signed [ACC_W-1:0] T_LIMIT = 56'sd6553600;
	localparam logic [23:0] DIV100_RECIP = 24'd10737419;  // ceil(2^30 / 100)
	localparam int DIV100_SHIFT = 30;

	localparam logic [14:0] PCT_SCALE = 15'd25600;        // 100 in Q.8

	typedef struct packed {
		logic                start;
		logic [DIV_DW-1:0]   dividend;
		logic [DIV_VW-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic                ovf;
		logic [DIV_QB-1:0]   quo;
	} div_rsp_t;

	typedef enum logic [15:0] {
		S_IDLE = 16'b0000_0000_0000_0001,
		S_MAT  = 16'b0000_0000_0000_0010,
		S_SUM  = 16'b0000_0000_0000_0100,
		S_NUM  = 16'b0000_0000_0000_1000,
		S_DEN  = 16'b0000_0000_0001_0000,
		S_CHK  = 16'b0000_0000_0010_0000,
		S_NDIV = 16'b0000_0000_0100_0000,
		S_N2   = 16'b0000_0000_1000_0000,
		S_N3   = 16'b0000_0001_0000_0000,
		S_T1   = 16'b0000_0010_0000_0000,
		S_T2   = 16'b0000_0100_0000_0000,
		S_T3   = 16'b0000_1000_0000_0000,
		S_QT   = 16'b0001_0000_0000_0000,
		S_PCT  = 16'b0010_0000_0000_0000,
		S_PDIV = 16'b0100_0000_0000_0000,
		S_OUT  = 16'b1000_0000_0000_0000
	} back_state_t;

endpackage

// File: rtl/core/rgbc_front.sv
// Front end: input saturation, compensation and running average update
module rgbc_front import rgbc_pkg::*; #(
	parameter int CHANNEL_WIDTH   = CHANNEL_WIDTH_DEF,
	parameter int AVG_WEIGHT_LOG2 = AVG_WEIGHT_LOG2_DEF,
	parameter int ENTRY_W         = 1 + 4 * VW + 4 * (CHANNEL_WIDTH + 8)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [IN_W-1:0]    clear_raw,
	input  logic [IN_W-1:0]    red_raw,
	input  logic [IN_W-1:0]    green_raw,
	input  logic [IN_W-1:0]    blue_raw,
	input  logic               comp_en,
	input  logic               pct_en,
	input  logic               q_full,
	output logic               q_push,
	output logic [ENTRY_W-1:0] q_data
);

	localparam int AW = CHANNEL_WIDTH + 8;
	localparam int SW = ((AW > VW + 8) ? AW : VW + 8) + AVG_WEIGHT_LOG2 + 1;
	localparam logic [31:0] CH_MAX = (32'd1 << CHANNEL_WIDTH) - 32'd1;

	logic [AW-1:0]    avg_q [4];
	logic [AW-1:0]    a_new [4];
	logic [IN_W-1:0]  raw [4];
	logic [VW-1:0]    vin [4];
	logic [VW-1:0]    v [4];
	logic [VW+4:0]    g_prod;
	logic [VW+16:0]   b_prod;
	logic [SW-1:0]    a_ext [4];
	logic [SW-1:0]    acc [4];

	function automatic logic [VW-1:0] sat_ch(input logic [31:0] x);
		return (x > CH_MAX) ? CH_MAX[VW-1:0] : x[VW-1:0];
	endfunction

	assign raw[0] = clear_raw;
	assign raw[1] = red_raw;
	assign raw[2] = green_raw;
	assign raw[3] = blue_raw;

	assign q_push = push & ~q_full;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			vin[i] = sat_ch(32'(raw[i]));
		end
		g_prod = vin[2] * COMP_G_MUL;
		b_prod = vin[3] * COMP_B_MUL;
		v[0] = vin[0];
		v[1] = vin[1];
		v[2] = comp_en ? sat_ch(32'(g_prod[VW+4:4])) : vin[2];
		v[3] = comp_en ? sat_ch(32'(b_prod[VW+16:16])) : vin[3];
		// avg*(2^W-1) + value<<8, then >> W
		for (int i = 0; i < 4; i++) begin
			a_ext[i] = SW'(avg_q[i]);
			acc[i]   = (a_ext[i] << AVG_WEIGHT_LOG2) - a_ext[i] + (SW'(v[i]) << 8);
			a_new[i] = acc[i][AVG_WEIGHT_LOG2+AW-1:AVG_WEIGHT_LOG2];
		end
		q_data[ENTRY_W-1] = pct_en;
		for (int i = 0; i < 4; i++) begin
			q_data[i*VW +: VW]          = v[i];
			q_data[4*VW + i*AW +: AW]   = a_new[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				avg_q[i] <= '0;
			end
		end else if (q_push) begin
			for (int i = 0; i < 4; i++) begin
				avg_q[i] <= a_new[i];
			end
		end
	end

endmodule

// File: rtl/core/rgbc_queue.sv
// Request queue between the front end and the back end
module rgbc_queue import rgbc_pkg::*; #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] data_in,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] data_out
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	logic [WIDTH-1:0] mem_q [QDEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CW'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign data_out = mem_q[rptr_q];

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= ptr_next(wptr_q);
			end
			if (do_pop) begin
				rptr_q <= ptr_next(rptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= data_in;
		end
	end

endmodule

// File: rtl/core/rgbc_div.sv
// Shared radix-4 restoring divider with quotient overflow detect
module rgbc_div import rgbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_STEPS + 1);
	localparam int HI_W  = DIV_DW - DIV_QB;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [DIV_QB-1:0] dlow_q;
	logic [DIV_QB-1:0] quo_q;

	logic [HI_W-1:0]   hi;
	logic              over;
	logic [DIV_VW:0]   r0, r1, d0, d1;
	logic [DIV_VW-1:0] ra, rb;
	logic              qa, qb;

	always_comb begin
		hi   = req.dividend[DIV_DW-1:DIV_QB];
		// quotient would not fit in DIV_QB bits
		over = (DIV_VW'(hi) >= req.divisor);
		r0 = {rem_q, dlow_q[DIV_QB-1]};
		d0 = r0 - {1'b0, dvs_q};
		qa = (r0 >= {1'b0, dvs_q});
		ra = qa ? d0[DIV_VW-1:0] : r0[DIV_VW-1:0];
		r1 = {ra, dlow_q[DIV_QB-2]};
		d1 = r1 - {1'b0, dvs_q};
		qb = (r1 >= {1'b0, dvs_q});
		rb = qb ? d1[DIV_VW-1:0] : r1[DIV_VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (over) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(DIV_STEPS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ovf_q  <= over;
			rem_q  <= DIV_VW'(hi);
			dlow_q <= req.dividend[DIV_QB-1:0];
			dvs_q  <= req.divisor;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= rb;
			dlow_q <= {dlow_q[DIV_QB-3:0], 2'b00};
			quo_q  <= {quo_q[DIV_QB-3:0], qa, qb};
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quo  = quo_q;

endmodule

// File: rtl/core/rgbc_back.sv
// Back end: XYZ matrix, CCT sequencer, percentage mode and result register
`include "rgbc_color_temperature_processor_macros.svh"

module rgbc_back import rgbc_pkg::*; #(
	parameter int CHANNEL_WIDTH = CHANNEL_WIDTH_DEF,
	parameter int ENTRY_W       = 1 + 4 * VW + 4 * (CHANNEL_WIDTH + 8)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  logic [ENTRY_W-1:0] q_data,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic [IN_W-1:0]    clear_out,
	output logic [IN_W-1:0]    red_out,
	output logic [IN_W-1:0]    green_out,
	output logic [IN_W-1:0]    blue_out,
	output logic [ILL_W-1:0]   illuminance,
	output logic [IN_W-1:0]    cct_kelvin,
	output logic               cct_valid
);

	localparam int AW = CHANNEL_WIDTH + 8;
	localparam logic [31:0] CH_MAX = (32'd1 << CHANNEL_WIDTH) - 32'd1;

	back_state_t state_q;
	logic [1:0]  row_q;
	logic [1:0]  ch_q;
	logic        out_valid_q;

	logic [VW-1:0]            v_q [4];
	logic [AW-1:0]            a_q [4];
	logic                     pct_q;
	logic signed [XW-1:0]     xyz_q [3];
	logic signed [XW-1:0]     s_q;
	logic signed [ND_W-1:0]   num_q;
	logic signed [ND_W-1:0]   den_q;
	logic                     n_neg_q;
	logic signed [N_W-1:0]    n_q;
	logic signed [N2_W-1:0]   n2_q;
	logic signed [N3_W-1:0]   n3_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [IN_W-1:0]          cct_q;
	logic                     cvalid_q;
	logic [ILL_W-1:0]         ill_q;
	logic [IN_W-1:0]          outv_q [4];

	logic [IN_W-1:0]          res_ch_q [4];
	logic [ILL_W-1:0]         res_ill_q;
	logic [IN_W-1:0]          res_cct_q;
	logic                     res_valid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic signed [VW:0]         vs [3];
	logic signed [2*VW+1:0]     mp [3];
	logic signed [XW-1:0]       row_sum;
	logic signed [XW+15:0]      pnum, pden;
	logic signed [XW-1:0]       pnum_sh, pden_sh, ysh;
	logic [ND_W-1:0]            num_abs, den_abs;
	logic                       zero_div;
	logic signed [2*N_W-1:0]    n2p;
	logic signed [N2_W+N_W-1:0] n3p;
	logic signed [ACC_W-1:0]    t3p, t2p, t1p, tsh;
	logic [46:0]                qp;
	logic [VW+14:0]             pprod;
	logic                       a_zero;
	logic                       load_out;

	rgbc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			vs[j] = $signed({1'b0, v_q[j+1]});
			mp[j] = MAT[row_q][j] * vs[j];
		end
		row_sum = XW'(mp[0]) + XW'(mp[1]) + XW'(mp[2]);
		pnum    = s_q * X_COEF;
		pden    = s_q * Y_COEF;
		pnum_sh = XW'(pnum >>> 16);
		pden_sh = XW'(pden >>> 16);
		ysh     = xyz_q[1] >>> 16;
		num_abs = num_q[ND_W-1] ? ND_W'(-num_q) : ND_W'(num_q);
		den_abs = den_q[ND_W-1] ? ND_W'(-den_q) : ND_W'(den_q);
		zero_div = (s_q == '0) || (den_q == '0);
		n2p = n_q * n_q;
		n3p = n2_q * n_q;
		t3p = CCT_C3 * n3_q;
		t2p = CCT_C2 * n2_q;
		t1p = CCT_C1 * n_q;
		tsh = acc_q >>> 16;
		qp  = tsh[22:0] * DIV100_RECIP;
		pprod  = v_q[ch_q] * PCT_SCALE;
		a_zero = (a_q[ch_q] == '0);

		div_req.start    = ((state_q == S_CHK) && !zero_div) ||
		                   ((state_q == S_PCT) && pct_q && !a_zero);
		div_req.dividend = (state_q == S_CHK) ? {num_abs, 16'b0} : DIV_DW'(pprod);
		div_req.divisor  = (state_q == S_CHK) ? den_abs : DIV_VW'(a_q[ch_q]);

		q_pop    = (state_q == S_IDLE) && !q_empty;
		load_out = (state_q == S_OUT) && (!out_valid_q || pop);
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					row_q <= '0;
					ch_q  <= '0;
					if (!q_empty) begin
						state_q <= S_MAT;
					end
				end
				S_MAT: begin
					row_q <= row_q + 2'd1;
					if (row_q == 2'd2) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: state_q <= S_NUM;
				S_NUM: state_q <= S_DEN;
				S_DEN: state_q <= S_CHK;
				S_CHK: state_q <= zero_div ? S_PCT : S_NDIV;
				S_NDIV: begin
					if (div_rsp.done) begin
						if (div_rsp.ovf || div_rsp.quo > N_LIMIT) begin
							state_q <= S_PCT;
						end else begin
							state_q <= S_N2;
						end
					end
				end
				S_N2: state_q <= S_N3;
				S_N3: state_q <= S_T1;
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= S_QT;
				S_QT: state_q <= S_PCT;
				S_PCT: begin
					if (!pct_q) begin
						state_q <= S_OUT;
					end else if (!a_zero) begin
						state_q <= S_PDIV;
					end else begin
						ch_q <= ch_q + 2'd1;
						if (ch_q == 2'd3) begin
							state_q <= S_OUT;
						end
					end
				end
				S_PDIV: begin
					if (div_rsp.done) begin
						ch_q    <= ch_q + 2'd1;
						state_q <= (ch_q == 2'd3) ? S_OUT : S_PCT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				pct_q <= q_data[ENTRY_W-1];
				for (int i = 0; i < 4; i++) begin
					v_q[i] <= q_data[i*VW +: VW];
					a_q[i] <= q_data[4*VW + i*AW +: AW];
				end
			end
			S_MAT: xyz_q[row_q] <= row_sum;
			S_SUM: begin
				s_q   <= xyz_q[0] + xyz_q[1] + xyz_q[2];
				ill_q <= ysh[ILL_W-1:0];
				for (int i = 0; i < 4; i++) begin
					outv_q[i] <= v_q[i][IN_W-1:0];
				end
			end
			S_NUM: num_q <= ND_W'(xyz_q[0]) - ND_W'(pnum_sh);
			S_DEN: den_q <= ND_W'(pden_sh) - ND_W'(xyz_q[1]);
			S_CHK: begin
				n_neg_q  <= num_q[ND_W-1] ^ den_q[ND_W-1];
				cct_q    <= '0;
				cvalid_q <= 1'b0;
			end
			S_NDIV: begin
				if (div_rsp.done) begin
					// far outside the fit range: pin to the end of the scale
					if (div_rsp.ovf || div_rsp.quo > N_LIMIT) begin
						cct_q <= n_neg_q ? '0 : '1;
					end
					n_q <= n_neg_q ? -$signed(div_rsp.quo) : $signed(div_rsp.quo);
				end
			end
			S_N2: n2_q  <= N2_W'(n2p >>> 16);
			S_N3: n3_q  <= N3_W'(n3p >>> 16);
			S_T1: acc_q <= t3p + CCT_C0;
			S_T2: acc_q <= acc_q + t2p;
			S_T3: acc_q <= acc_q + t1p;
			S_QT: begin
				priority if (acc_q[ACC_W-1]) begin
					cct_q <= '0;
				end else if (tsh >= T_LIMIT) begin
					cct_q <= '1;
				end else begin
					cct_q    <= qp[DIV100_SHIFT+IN_W-1:DIV100_SHIFT];
					cvalid_q <= 1'b1;
				end
			end
			S_PCT: begin
				if (pct_q && a_zero) begin
					outv_q[ch_q] <= '0;
				end
			end
			S_PDIV: begin
				if (div_rsp.done) begin
					if (div_rsp.ovf || 32'(div_rsp.quo) > CH_MAX) begin
						outv_q[ch_q] <= CH_MAX[IN_W-1:0];
					end else begin
						outv_q[ch_q] <= div_rsp.quo[IN_W-1:0];
					end
				end
			end
			S_OUT: begin
				if (load_out) begin
					for (int i = 0; i < 4; i++) begin
						res_ch_q[i] <= outv_q[i];
					end
					res_ill_q   <= ill_q;
					res_cct_q   <= cct_q;
					res_valid_q <= cvalid_q;
				end
			end
			default: ;
		endcase
	end

	assign empty       = ~out_valid_q;
	assign clear_out   = res_ch_q[0];
	assign red_out     = res_ch_q[1];
	assign green_out   = res_ch_q[2];
	assign blue_out    = res_ch_q[3];
	assign illuminance = res_ill_q;
	assign cct_kelvin  = res_cct_q;
	assign cct_valid   = res_valid_q;

	`RGBC_ASSERT_IMP(a_div_done_waited, div_rsp.done, (state_q == S_NDIV) || (state_q == S_PDIV), "divider result with no state waiting for it")
	`RGBC_ASSERT_NXT(a_out_stall_holds, (state_q == S_OUT) && out_valid_q && !pop, state_q == S_OUT, "result overwrote an untaken result")
	`RGBC_ASSERT_IMP(a_pdiv_needs_pct, state_q == S_PDIV, pct_q, "percent division outside percentage mode")

endmodule

// File: rtl/core/rgbc_color_temperature_processor.sv
// Flow: a request runs through the XYZ matrix, the sums, the n divide and the cubic,
// which a zero divisor or an out-of-range n cuts short; in percentage mode each
// channel then takes a divide, or a short step that zeroes it when its average is zero.
// Requests: the back end takes a new request only once the last result is loaded; the
// shared 2-bit-per-cycle divider (12 steps) serves n and each percent value.
// Reset: asynchronous active-low arst_n clears averages, config and queue.
module rgbc_color_temperature_processor import rgbc_pkg::*; #(
	parameter int AVG_WEIGHT_LOG2 = AVG_WEIGHT_LOG2_DEF,
	parameter int CHANNEL_WIDTH   = CHANNEL_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [IN_W-1:0]      clear_raw,
	input  logic [IN_W-1:0]      red_raw,
	input  logic [IN_W-1:0]      green_raw,
	input  logic [IN_W-1:0]      blue_raw,
	output logic                 empty,
	input  logic                 pop,
	output logic [IN_W-1:0]      clear_out,
	output logic [IN_W-1:0]      red_out,
	output logic [IN_W-1:0]      green_out,
	output logic [IN_W-1:0]      blue_out,
	output logic [ILL_W-1:0]     illuminance,
	output logic [IN_W-1:0]      cct_kelvin,
	output logic                 cct_valid,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data
);

	localparam int ENTRY_W = 1 + 4 * VW + 4 * (CHANNEL_WIDTH + 8);

	logic               comp_en_q;
	logic               pct_en_q;
	logic               q_push;
	logic               q_pop;
	logic               q_empty;
	logic [ENTRY_W-1:0] q_in;
	logic [ENTRY_W-1:0] q_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_en_q <= 1'b0;
			pct_en_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_COMPENSATE: comp_en_q <= cfg_data;
				CFG_PERCENTAGE: pct_en_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	rgbc_front #(
		.CHANNEL_WIDTH   (CHANNEL_WIDTH),
		.AVG_WEIGHT_LOG2 (AVG_WEIGHT_LOG2),
		.ENTRY_W         (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.clear_raw (clear_raw),
		.red_raw   (red_raw),
		.green_raw (green_raw),
		.blue_raw  (blue_raw),
		.comp_en   (comp_en_q),
		.pct_en    (pct_en_q),
		.q_full    (full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	rgbc_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.data_in  (q_in),
		.full     (full),
		.pop      (q_pop),
		.empty    (q_empty),
		.data_out (q_out)
	);

	rgbc_back #(
		.CHANNEL_WIDTH (CHANNEL_WIDTH),
		.ENTRY_W       (ENTRY_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_out),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.clear_out   (clear_out),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.illuminance (illuminance),
		.cct_kelvin  (cct_kelvin),
		.cct_valid   (cct_valid)
	);

endmodule
